### design/rbe_pkg.sv
// Shared types, constants and saturation helper for the rigid body Euler step.
// No dependencies; imported by the interfaces, the divider and the top level.
package rbe_pkg;

   // Q16.16 word and the quotient width of the velocity division
   localparam int unsigned WORD_W = 32;
   localparam int unsigned MASS_W = 31;
   localparam int unsigned STEP_W = 16;
   localparam int unsigned DIV_BITS = 47;   // |force * step| < 2^47

   // Register indexes of the configuration port
   localparam logic CSR_TIME_STEP = 1'b0;
   localparam logic CSR_GRAVITY_Y = 1'b1;

   localparam logic [STEP_W-1:0] TIME_STEP_RESET = 16'd1092;
   localparam logic signed [WORD_W-1:0] GRAVITY_Y_RESET = -32'sd642908;

   localparam logic signed [WORD_W-1:0] Q32_MAX = 32'sh7fff_ffff;
   localparam logic signed [WORD_W-1:0] Q32_MIN = 32'sh8000_0000;

   typedef logic signed [WORD_W-1:0] q32_type;

   // One body as it enters the block
   typedef struct packed {
      logic                  has_pos;
      logic [MASS_W-1:0]     mass;
      logic [2:0][WORD_W-1:0] force_v;
      logic [2:0][WORD_W-1:0] velocity_v;
      logic [2:0][WORD_W-1:0] position_v;
   } body_type;

   // Sideband carried through the divider
   typedef struct packed {
      body_type   body;
      logic [2:0] neg;
   } side_type;

   // Clamp a wide signed value to the Q16.16 range
   function automatic q32_type sat_q32(input logic signed [49:0] x);
      q32_type r;
      if (x > 50'(Q32_MAX)) begin
         r = Q32_MAX;
      end else if (x < 50'(Q32_MIN)) begin
         r = Q32_MIN;
      end else begin
         r = x[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

### design/rbe_req_if.sv
// Request channel carrying one body per transaction.
// Depends on rbe_pkg for field widths.
interface rbe_req_if import rbe_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic                      has_pos;
   logic [MASS_W-1:0]         mass;
   logic signed [WORD_W-1:0]  force_x;
   logic signed [WORD_W-1:0]  force_y;
   logic signed [WORD_W-1:0]  force_z;
   logic signed [WORD_W-1:0]  velocity_x;
   logic signed [WORD_W-1:0]  velocity_y;
   logic signed [WORD_W-1:0]  velocity_z;
   logic signed [WORD_W-1:0]  position_x;
   logic signed [WORD_W-1:0]  position_y;
   logic signed [WORD_W-1:0]  position_z;

   modport source (output valid, has_pos, mass, force_x, force_y, force_z,
                   velocity_x, velocity_y, velocity_z, position_x, position_y,
                   position_z, input ready);
   modport sink (input valid, has_pos, mass, force_x, force_y, force_z,
                 velocity_x, velocity_y, velocity_z, position_x, position_y,
                 position_z, output ready);
endinterface

### design/rbe_rsp_if.sv
// Response channel carrying one updated body per transaction.
// Depends on rbe_pkg for field widths.
interface rbe_rsp_if import rbe_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic signed [WORD_W-1:0]  new_force_x;
   logic signed [WORD_W-1:0]  new_force_y;
   logic signed [WORD_W-1:0]  new_force_z;
   logic signed [WORD_W-1:0]  new_velocity_x;
   logic signed [WORD_W-1:0]  new_velocity_y;
   logic signed [WORD_W-1:0]  new_velocity_z;
   logic signed [WORD_W-1:0]  new_position_x;
   logic signed [WORD_W-1:0]  new_position_y;
   logic signed [WORD_W-1:0]  new_position_z;

   modport source (output valid, new_force_x, new_force_y, new_force_z,
                   new_velocity_x, new_velocity_y, new_velocity_z,
                   new_position_x, new_position_y, new_position_z, input ready);
   modport sink (input valid, new_force_x, new_force_y, new_force_z,
                 new_velocity_x, new_velocity_y, new_velocity_z,
                 new_position_x, new_position_y, new_position_z, output ready);
endinterface

### design/rbe_div_pipe.sv
// Three-lane pipelined restoring divider, one quotient bit per stage.
// Depends on rbe_pkg; the divisor is the mass carried in the sideband.
module rbe_div_pipe import rbe_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [2:0][DIV_BITS-1:0]  in_dividend,
   input  side_type                  in_side,
   output logic                      out_valid,
   output logic [2:0][DIV_BITS-1:0]  out_quotient,
   output side_type                  out_side
);

   logic                     valid_ff [0:DIV_BITS];
   logic [2:0][MASS_W-1:0]   rem_ff   [0:DIV_BITS];
   logic [2:0][DIV_BITS-1:0] num_ff   [0:DIV_BITS];
   side_type                 side_ff  [0:DIV_BITS];

   // stage zero is the unregistered input
   assign valid_ff[0] = in_valid;
   assign rem_ff[0]   = '0;
   assign num_ff[0]   = in_dividend;
   assign side_ff[0]  = in_side;

   for (genvar s = 1; s <= DIV_BITS; s++) begin : g_stage
      logic [2:0][MASS_W-1:0]   rem_in;
      logic [2:0][DIV_BITS-1:0] num_in;

      // one compare-subtract per lane; the dividend word collects quotient bits
      always_comb begin
         logic [MASS_W:0] trial;
         logic            ge;
         for (int k = 0; k < 3; k++) begin
            trial = {rem_ff[s-1][k], num_ff[s-1][k][DIV_BITS-1]};
            ge = trial >= {1'b0, side_ff[s-1].body.mass};
            rem_in[k] = ge ? MASS_W'(trial - {1'b0, side_ff[s-1].body.mass})
                           : trial[MASS_W-1:0];
            num_in[k] = {num_ff[s-1][k][DIV_BITS-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_ff[s-1];
         end
         if (en) begin
            rem_ff[s]  <= rem_in;
            num_ff[s]  <= num_in;
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid    = valid_ff[DIV_BITS];
   assign out_quotient = num_ff[DIV_BITS];
   assign out_side     = side_ff[DIV_BITS];

endmodule

### design/rigid_body_euler_step_top.sv
// Top level of the rigid body semi-implicit Euler step.
// Depends on rbe_pkg, rbe_req_if, rbe_rsp_if and rbe_div_pipe.
//
// Usage:
//  - req: one body per transaction (valid/ready). rsp: one updated body per
//    request, in order. csr_we/csr_index/csr_wdata write time_step (index 0)
//    and gravity_y (index 1); write only while the block is idle.
//  - Throughput: one body per cycle while the response is not stalled. The
//    velocity division is a 47-stage restoring divider, one quotient bit per stage,
//    most of the 5 + 47 + 3 = 55 register stages from the request to the
//    response register; a stalled response holds each body where it is.
//  - The whole pipeline advances together: a stalled response holds every
//    stage, and req.ready drops until the output register empties or is taken.
//  - Reset (synchronous, active high) empties the pipeline and restores
//    time_step to 1092 (about 1/60 s) and gravity_y to about -9.81.
//  - A body without a position passes unchanged; zero mass leaves velocity
//    unchanged while the position still integrates.
module rigid_body_euler_step_top import rbe_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   rbe_req_if.sink             req,
   rbe_rsp_if.source           rsp,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [WORD_W-1:0]   csr_wdata
);

   logic [STEP_W-1:0] time_step_ff;
   q32_type           gravity_y_ff;
   logic              en;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= TIME_STEP_RESET;
         gravity_y_ff <= GRAVITY_Y_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TIME_STEP: time_step_ff <= csr_wdata[STEP_W-1:0];
            CSR_GRAVITY_Y: gravity_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic out_valid_ff;
   assign en = !out_valid_ff || rsp.ready;
   assign req.ready = en;

   logic signed [STEP_W:0] ts_s;
   assign ts_s = {1'b0, time_step_ff};

   // stage 1: input capture
   logic     v1_ff;
   body_type b1_ff, b1_in;
   always_comb begin
      b1_in.has_pos = req.has_pos;
      b1_in.mass = req.mass;
      b1_in.force_v = {req.force_z, req.force_y, req.force_x};
      b1_in.velocity_v = {req.velocity_z, req.velocity_y, req.velocity_x};
      b1_in.position_v = {req.position_z, req.position_y, req.position_x};
   end

   // stage 2: mass times gravity
   logic                v2_ff;
   body_type            b2_ff;
   logic signed [63:0]  gprod2_ff, gprod2_in;
   assign gprod2_in = signed'({1'b0, b1_ff.mass}) * gravity_y_ff;

   // stage 3: gravity added to the y force
   logic                     v3_ff;
   body_type                 b3_ff;
   logic [2:0][WORD_W-1:0]   wf3_ff, wf3_in;
   always_comb begin
      wf3_in = b2_ff.force_v;
      if (b2_ff.has_pos) begin
         wf3_in[1] = sat_q32(50'(signed'(b2_ff.force_v[1]))
                             + 50'(signed'(gprod2_ff[63:16])));
      end
   end

   // stage 4: force times step
   logic                      v4_ff;
   body_type                  b4_ff;
   logic signed [48:0]        fts4_ff [3];
   logic signed [48:0]        fts4_in [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         fts4_in[k] = 49'(signed'(wf3_ff[k]) * ts_s);
      end
   end

   // stage 5: magnitude and sign for the divider
   logic                      v5_ff;
   side_type                  s5_ff, s5_in;
   logic [2:0][DIV_BITS-1:0]  mag5_ff, mag5_in;
   always_comb begin
      logic [48:0] a;
      s5_in.body = b4_ff;
      for (int k = 0; k < 3; k++) begin
         s5_in.neg[k] = fts4_ff[k][48];
         a = fts4_ff[k][48] ? 49'(-fts4_ff[k]) : fts4_ff[k];
         mag5_in[k] = a[DIV_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      if (en) begin
         b1_ff     <= b1_in;
         b2_ff     <= b1_ff;
         gprod2_ff <= gprod2_in;
         b3_ff     <= b2_ff;
         wf3_ff    <= wf3_in;
         b4_ff     <= b3_ff;
         fts4_ff   <= fts4_in;
         s5_ff     <= s5_in;
         mag5_ff   <= mag5_in;
      end
   end

   // velocity division
   logic                      vd;
   logic [2:0][DIV_BITS-1:0]  qd;
   side_type                  sd;
   rbe_div_pipe u_div (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (v5_ff),
      .in_dividend  (mag5_ff),
      .in_side      (s5_ff),
      .out_valid    (vd),
      .out_quotient (qd),
      .out_side     (sd)
   );

   // stage 6: velocity update
   logic                    v6_ff;
   body_type                b6_ff;
   logic [2:0][WORD_W-1:0]  nv6_ff, nv6_in;
   always_comb begin
      logic signed [49:0] dv;
      for (int k = 0; k < 3; k++) begin
         dv = sd.neg[k] ? -50'(qd[k]) : 50'(qd[k]);
         nv6_in[k] = sd.body.velocity_v[k];
         if (sd.body.has_pos && (sd.body.mass != '0)) begin
            nv6_in[k] = sat_q32(50'(signed'(sd.body.velocity_v[k])) + dv);
         end
      end
   end

   // stage 7: new velocity times step
   logic                    v7_ff;
   body_type                b7_ff;
   logic [2:0][WORD_W-1:0]  nv7_ff;
   logic signed [48:0]      vts7_ff [3];
   logic signed [48:0]      vts7_in [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         vts7_in[k] = 49'(signed'(nv6_ff[k]) * ts_s);
      end
   end

   // stage 8: position update into the output register
   logic [2:0][WORD_W-1:0]  of_in, ov_in, op_in;
   logic [2:0][WORD_W-1:0]  of_ff, ov_ff, op_ff;
   logic                    oh_ff;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         of_in[k] = b7_ff.has_pos ? '0 : b7_ff.force_v[k];
         ov_in[k] = nv7_ff[k];
         op_in[k] = b7_ff.position_v[k];
         if (b7_ff.has_pos) begin
            op_in[k] = sat_q32(50'(signed'(b7_ff.position_v[k]))
                               + 50'(signed'(vts7_ff[k][48:16])));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         v6_ff        <= vd;
         v7_ff        <= v6_ff;
         out_valid_ff <= v7_ff;
      end
      if (en) begin
         b6_ff   <= sd.body;
         nv6_ff  <= nv6_in;
         b7_ff   <= b6_ff;
         nv7_ff  <= nv6_ff;
         vts7_ff <= vts7_in;
         of_ff   <= of_in;
         ov_ff   <= ov_in;
         op_ff   <= op_in;
         oh_ff   <= b7_ff.has_pos;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.new_force_x    = of_ff[0];
   assign rsp.new_force_y    = of_ff[1];
   assign rsp.new_force_z    = of_ff[2];
   assign rsp.new_velocity_x = ov_ff[0];
   assign rsp.new_velocity_y = ov_ff[1];
   assign rsp.new_velocity_z = ov_ff[2];
   assign rsp.new_position_x = op_ff[0];
   assign rsp.new_position_y = op_ff[1];
   assign rsp.new_position_z = op_ff[2];

`ifndef SYNTHESIS
   // an updated body always leaves with its force cleared
   a_force_cleared: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && oh_ff) |-> (of_ff == '0))
      else $error("force not cleared on updated body");

   // zero mass leaves velocity untouched
   a_zero_mass_vel: assert property (@(posedge clock) disable iff (reset)
      (en && vd && (sd.body.mass == '0)) |=> (nv6_ff == b6_ff.velocity_v))
      else $error("velocity changed for zero mass");

   // a body without a position passes its position through
   a_pass_position: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !oh_ff && $past(en) && $past(v7_ff))
         |-> (op_ff == $past(b7_ff.position_v)))
      else $error("position changed without update");
`endif

endmodule
